### src/atts_pkg.sv
`default_nettype none

package atts_pkg;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_STARTUP  = 2'd2,
        MODE_AIRBORNE = 2'd3
    } t_mode;

    localparam logic [16:0] Q_MAX          = 17'd131071;
    localparam logic [16:0] Q_ONE          = 17'd65536;
    localparam logic [16:0] Q_HALF         = 17'd32768;
    // thrust * 5 < 1.0
    localparam logic [16:0] Q_FIFTH_LIM    = 17'd13108;
    localparam logic [16:0] STICK_LOW      = 17'd3277;
    localparam logic signed [15:0] HEIGHT_MAX_MM = 16'sd300;

    // dt / 5 = (dt * 52429) >> 18, exact over 16 bits
    localparam logic [15:0] DIV5_MUL       = 16'd52429;
    localparam int          DIV5_SHIFT     = 18;

    localparam logic [15:0] FORCE_SCALE_RST = 16'd1024;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic {
        CFG_AUTO_ENABLE = 1'b0,
        CFG_FORCE_SCALE = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        REQ_TICK         = 1'b0,
        REQ_SET_THROTTLE = 1'b1
    } t_req;

endpackage

`default_nettype wire

### src/auto_thrust_takeoff_sequencer_core.sv
// A result passes the input register, state snapshot and output register to
// o_m_tdata. Throughput: one item per cycle unless i_m_tready stalls the
// output; a single registered pass updates mode/thrust/cap; force multiply is next.
// Reset (i_rst_n low, synchronous): mode off, thrust 0, cap 1.0,
// auto_enable 1, force_scale 1024, pipeline empty.
`default_nettype none

module auto_thrust_takeoff_sequencer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [16:0] throttle_value, [17] rc_valid, [34:18] stick_value, [35] new_command,
    // [36] remote_source, [37] motors_on, [38] airborne_flag,
    // [54:39] height_mm, [70:55] tick_seconds, [71] zero
    input  wire logic [atts_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // [0] req_type
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [16:0] thrust_out, [33:17] force_z, [35:34] mode_out, [36] shutdown_req,
    // [39:37] zero
    output logic [atts_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import atts_pkg::*;

    // configuration
    logic        r_auto;
    logic [15:0] r_force_scale;

    // sequencer state
    t_mode       r_mode,  n_mode;
    logic [16:0] r_thrust, n_thrust;
    logic [16:0] r_cap,    n_cap;

    // stage 1: input register
    logic        r_s1_valid;
    logic        r_s1_req;
    logic [16:0] r_s1_tv;
    logic        r_s1_rc_valid;
    logic [16:0] r_s1_rc;
    logic        r_s1_newcmd;
    logic        r_s1_remote;
    logic        r_s1_motors;
    logic        r_s1_air;
    logic signed [15:0] r_s1_height;
    logic [13:0] r_s1_dt5;

    // stage 2: updated state snapshot
    logic        r_s2_valid;
    logic [16:0] r_s2_thrust;
    t_mode       r_s2_mode;
    logic        r_s2_shutdown;

    // output register
    logic        r_out_valid;
    logic [16:0] r_out_thrust;
    logic [16:0] r_out_force;
    t_mode       r_out_mode;
    logic        r_out_shutdown;

    logic        w_out_ready, w_s2_ready, w_s1_fire, w_in_fire;
    logic [31:0] w_dt_prod;
    logic [32:0] w_force_prod;

    logic        w_stick_low, w_shutdown, w_height_ok, w_height_pos;
    t_mode       w_mode_pre;
    logic [16:0] w_lvl_pre, w_cap_new;
    logic [13:0] w_q5, w_q10;
    logic [16:0] w_r1, w_r2, w_r3, w_ramp;

    function automatic logic [16:0] sat_add(input logic [16:0] a, input logic [13:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {4'd0, b};
        return (s > {1'b0, Q_MAX}) ? Q_MAX : s[16:0];
    endfunction

    // handshake
    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign w_s1_fire   = r_s1_valid && w_s2_ready;
    assign o_s_tready  = !r_s1_valid || w_s2_ready;
    assign w_in_fire   = i_s_tvalid && o_s_tready;

    assign w_dt_prod = i_s_tdata[70:55] * DIV5_MUL;

    // tick decode
    assign w_stick_low  = r_s1_rc < STICK_LOW;
    assign w_shutdown   = !r_s1_req && r_s1_rc_valid && w_stick_low;
    assign w_height_pos = r_s1_height > 16'sd0;
    assign w_height_ok  = w_height_pos && (r_s1_height < HEIGHT_MAX_MM);
    assign w_q5         = r_s1_dt5;
    assign w_q10        = {1'b0, r_s1_dt5[13:1]};

    // mode after shutdown and new command
    always_comb begin
        w_mode_pre = r_mode;
        if (w_shutdown) begin
            w_mode_pre = r_auto ? MODE_IDLE : MODE_OFF;
        end
        if (r_s1_newcmd) begin
            w_mode_pre = MODE_AIRBORNE;
        end
    end

    // next mode
    always_comb begin
        n_mode = w_mode_pre;
        if (r_s1_req == REQ_SET_THROTTLE) begin
            n_mode = (r_s1_tv == 17'd0) ? MODE_IDLE : MODE_AIRBORNE;
        end else if (r_auto) begin
            case (w_mode_pre)
                MODE_OFF: begin
                    if (!r_s1_motors && w_height_ok) n_mode = MODE_IDLE;
                end
                MODE_IDLE: begin
                    if (!r_s1_air && r_s1_motors) begin
                        n_mode = w_height_pos ? MODE_STARTUP : MODE_OFF;
                    end
                end
                MODE_STARTUP: begin
                    if (r_s1_air) n_mode = MODE_AIRBORNE;
                end
                default: n_mode = w_mode_pre;
            endcase
        end
    end

    // thrust and cap after the stick step
    always_comb begin
        w_lvl_pre = r_thrust;
        w_cap_new = r_cap;
        if (r_s1_rc_valid) begin
            if (w_stick_low && r_auto) w_lvl_pre = 17'd0;
            if (r_auto) begin
                w_cap_new = r_s1_rc;
            end else if (r_s1_remote) begin
                w_lvl_pre = r_s1_rc;
            end
        end
    end

    // takeoff ramp
    always_comb begin
        w_r1 = (w_lvl_pre < Q_FIFTH_LIM) ? sat_add(w_lvl_pre, w_q10) : w_lvl_pre;
        w_r2 = (w_r1 < Q_HALF) ? sat_add(w_r1, w_q5) : w_r1;
        w_r3 = (w_r2 < Q_ONE) ? sat_add(w_r2, w_q10) : w_r2;
        w_ramp = (w_r3 > w_cap_new) ? w_cap_new : w_r3;
    end

    // next thrust and cap
    always_comb begin
        n_thrust = r_thrust;
        n_cap    = r_cap;
        if (r_s1_req == REQ_SET_THROTTLE) begin
            n_thrust = r_s1_tv;
        end else begin
            n_cap    = w_cap_new;
            n_thrust = w_lvl_pre;
            if (r_auto) begin
                case (w_mode_pre)
                    MODE_IDLE: begin
                        if (!(!r_s1_air && r_s1_motors)) n_thrust = 17'd0;
                    end
                    MODE_STARTUP: begin
                        if (!r_s1_air) n_thrust = w_ramp;
                    end
                    MODE_AIRBORNE: begin
                        if (w_lvl_pre > w_cap_new) n_thrust = w_cap_new;
                    end
                    default: n_thrust = w_lvl_pre;
                endcase
            end
        end
    end

    assign w_force_prod = r_s2_thrust * r_force_scale;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto        <= 1'b1;
            r_force_scale <= FORCE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_AUTO_ENABLE: r_auto        <= i_cfg_wdata[0];
                CFG_FORCE_SCALE: r_force_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OFF;
            r_thrust    <= 17'd0;
            r_cap       <= Q_ONE;
        end else begin
            if (o_s_tready) r_s1_valid <= i_s_tvalid;
            if (w_s2_ready) r_s2_valid <= r_s1_valid;
            if (w_out_ready) r_out_valid <= r_s2_valid;
            if (w_s1_fire) begin
                r_mode   <= n_mode;
                r_thrust <= n_thrust;
                r_cap    <= n_cap;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_req      <= i_s_tuser;
            r_s1_tv       <= i_s_tdata[16:0];
            r_s1_rc_valid <= i_s_tdata[17];
            r_s1_rc       <= i_s_tdata[34:18];
            r_s1_newcmd   <= i_s_tdata[35];
            r_s1_remote   <= i_s_tdata[36];
            r_s1_motors   <= i_s_tdata[37];
            r_s1_air      <= i_s_tdata[38];
            r_s1_height   <= i_s_tdata[54:39];
            r_s1_dt5      <= w_dt_prod[DIV5_SHIFT+13:DIV5_SHIFT];
        end
        if (w_s1_fire) begin
            r_s2_thrust   <= n_thrust;
            r_s2_mode     <= n_mode;
            r_s2_shutdown <= w_shutdown;
        end
        if (r_s2_valid && w_out_ready) begin
            r_out_thrust   <= r_s2_thrust;
            r_out_force    <= w_force_prod[32:16];
            r_out_mode     <= r_s2_mode;
            r_out_shutdown <= r_s2_shutdown;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out_shutdown, r_out_mode, r_out_force, r_out_thrust};

endmodule

`default_nettype wire

### src/atts_checker.sv
`default_nettype none

module atts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [atts_pkg::OUT_TDATA_W-1:0] i_m_tdata
);
    import atts_pkg::*;

    // empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input not ready while output empty");

    // force = thrust * scale / 65536 with scale below 65536
    a_force_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[33:17] <= i_m_tdata[16:0]))
        else $error("force exceeds thrust");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result present after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

endmodule

bind auto_thrust_takeoff_sequencer_core atts_checker u_atts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
